### design/pfp_pkg.sv
package pfp_pkg;

	// Default width of the pixel coordinates.
	localparam int COORD_BITS_DEF = 12;

	// Result coordinates are 15-bit two's complement and clamp at the range ends.
	localparam int FOOT_BITS = 15;
	localparam logic signed [31:0] FOOT_MAX = 32'sd16383;
	localparam logic signed [31:0] FOOT_MIN = -32'sd16384;

	// Control flags that travel with every request through the pipeline.
	typedef struct packed {
		logic valid;
		logic vert;
		logic horiz;
		logic neg_x;
		logic neg_y;
	} pfp_ctrl_t;

	// Clamp a signed value into the result range and keep the low bits.
	function automatic logic [FOOT_BITS-1:0] pfp_sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > FOOT_MAX) begin
			r = FOOT_MAX;
		end else if (v < FOOT_MIN) begin
			r = FOOT_MIN;
		end else begin
			r = v;
		end
		return r[FOOT_BITS-1:0];
	endfunction

	// Clock edges from the accepting edge to the edge that takes the result.
	function automatic int pfp_latency(input int coord_bits);
		return coord_bits + 7;
	endfunction

endpackage

### design/pfp_front.sv
module pfp_front import pfp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [COORD_BITS-1:0]     point_x,
	input  logic [COORD_BITS-1:0]     point_y,
	input  logic [COORD_BITS-1:0]     line_start_x,
	input  logic [COORD_BITS-1:0]     line_start_y,
	input  logic [COORD_BITS-1:0]     line_end_x,
	input  logic [COORD_BITS-1:0]     line_end_y,
	output pfp_ctrl_t                 ctrl,
	output logic [3*COORD_BITS+1:0]   rem_x,
	output logic [3*COORD_BITS+1:0]   rem_y,
	output logic [2*COORD_BITS:0]     den,
	output logic [COORD_BITS-1:0]     spec_x,
	output logic [COORD_BITS-1:0]     spec_y
);

	localparam int N  = COORD_BITS;
	localparam int DB = N + 1;       // coordinate differences
	localparam int PB = 2 * N + 2;   // products of two differences
	localparam int NS = 3 * N + 3;   // signed numerators
	localparam int NW = 3 * N + 2;   // numerator magnitudes
	localparam int DW = 2 * N + 1;   // denominator

	// Stage 1: differences and line classification.
	pfp_ctrl_t                ctrl_s1;
	logic signed [DB-1:0]     dx_s1, dy_s1, ex_s1, ey_s1;
	logic [N-1:0]             x0_s1, y0_s1, x1_s1, y1_s1, spx_s1, spy_s1;

	// Stage 2: squares and product of the direction components.
	pfp_ctrl_t                ctrl_s2;
	logic signed [PB-1:0]     dxx_s2, dyy_s2, dxy_s2;
	logic signed [DB-1:0]     ex_s2, ey_s2;
	logic [N-1:0]             x0_s2, y0_s2, x1_s2, y1_s2, spx_s2, spy_s2;

	// Stage 3: weighted coordinate terms and the denominator.
	pfp_ctrl_t                ctrl_s3;
	logic signed [NS-1:0]     tx0_s3, tx1_s3, txe_s3, ty0_s3, ty1_s3, tye_s3;
	logic [DW-1:0]            den_s3;
	logic [N-1:0]             spx_s3, spy_s3;

	// Stage 4: signed numerators.
	pfp_ctrl_t                ctrl_s4;
	logic signed [NS-1:0]     numx_s4, numy_s4;
	logic [DW-1:0]            den_s4;
	logic [N-1:0]             spx_s4, spy_s4;

	// Stage 5: sign and magnitude for the divider.
	pfp_ctrl_t                ctrl_s5;
	logic [NW-1:0]            magx_s5, magy_s5;
	logic [DW-1:0]            den_s5;
	logic [N-1:0]             spx_s5, spy_s5;

	logic                     vert_d, horiz_d;
	logic signed [NS-1:0]     negx_d, negy_d;

	assign vert_d  = (line_start_x == line_end_x);
	assign horiz_d = !vert_d && (line_start_y == line_end_y);
	assign negx_d  = -numx_s4;
	assign negy_d  = -numy_s4;

	// Control flags of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else begin
			ctrl_s1 <= '{valid: in_valid, vert: vert_d, horiz: horiz_d,
				neg_x: 1'b0, neg_y: 1'b0};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= '{valid: ctrl_s4.valid, vert: ctrl_s4.vert, horiz: ctrl_s4.horiz,
				neg_x: numx_s4[NS-1], neg_y: numy_s4[NS-1]};
		end
	end

	// Data path of the five stages.
	always_ff @(posedge clk) begin
		dx_s1  <= $signed({1'b0, line_end_x}) - $signed({1'b0, line_start_x});
		dy_s1  <= $signed({1'b0, line_end_y}) - $signed({1'b0, line_start_y});
		ex_s1  <= $signed({1'b0, point_x}) - $signed({1'b0, line_start_x});
		ey_s1  <= $signed({1'b0, point_y}) - $signed({1'b0, line_start_y});
		x0_s1  <= point_x;
		y0_s1  <= point_y;
		x1_s1  <= line_start_x;
		y1_s1  <= line_start_y;
		spx_s1 <= vert_d ? line_start_x : point_x;
		spy_s1 <= vert_d ? point_y : line_start_y;

		dxx_s2 <= dx_s1 * dx_s1;
		dyy_s2 <= dy_s1 * dy_s1;
		dxy_s2 <= dx_s1 * dy_s1;
		ex_s2  <= ex_s1;
		ey_s2  <= ey_s1;
		x0_s2  <= x0_s1;
		y0_s2  <= y0_s1;
		x1_s2  <= x1_s1;
		y1_s2  <= y1_s1;
		spx_s2 <= spx_s1;
		spy_s2 <= spy_s1;

		tx0_s3 <= dxx_s2 * $signed({1'b0, x0_s2});
		tx1_s3 <= dyy_s2 * $signed({1'b0, x1_s2});
		txe_s3 <= dxy_s2 * ey_s2;
		ty0_s3 <= dyy_s2 * $signed({1'b0, y0_s2});
		ty1_s3 <= dxx_s2 * $signed({1'b0, y1_s2});
		tye_s3 <= dxy_s2 * ex_s2;
		den_s3 <= DW'(dxx_s2 + dyy_s2);
		spx_s3 <= spx_s2;
		spy_s3 <= spy_s2;

		numx_s4 <= tx0_s3 + tx1_s3 + txe_s3;
		numy_s4 <= ty0_s3 + ty1_s3 + tye_s3;
		den_s4  <= den_s3;
		spx_s4  <= spx_s3;
		spy_s4  <= spy_s3;

		magx_s5 <= numx_s4[NS-1] ? negx_d[NW-1:0] : numx_s4[NW-1:0];
		magy_s5 <= numy_s4[NS-1] ? negy_d[NW-1:0] : numy_s4[NW-1:0];
		den_s5  <= den_s4;
		spx_s5  <= spx_s4;
		spy_s5  <= spy_s4;
	end

	assign ctrl   = ctrl_s5;
	assign rem_x  = magx_s5;
	assign rem_y  = magy_s5;
	assign den    = den_s5;
	assign spec_x = spx_s5;
	assign spec_y = spy_s5;

endmodule

### design/pfp_div_cell.sv
module pfp_div_cell import pfp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int SHIFT      = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pfp_ctrl_t                 ctrl_in,
	input  logic [3*COORD_BITS+1:0]   rem_x_in,
	input  logic [3*COORD_BITS+1:0]   rem_y_in,
	input  logic [2*COORD_BITS:0]     den_in,
	input  logic [COORD_BITS:0]       quo_x_in,
	input  logic [COORD_BITS:0]       quo_y_in,
	input  logic [COORD_BITS-1:0]     spec_x_in,
	input  logic [COORD_BITS-1:0]     spec_y_in,
	output pfp_ctrl_t                 ctrl_out,
	output logic [3*COORD_BITS+1:0]   rem_x_out,
	output logic [3*COORD_BITS+1:0]   rem_y_out,
	output logic [2*COORD_BITS:0]     den_out,
	output logic [COORD_BITS:0]       quo_x_out,
	output logic [COORD_BITS:0]       quo_y_out,
	output logic [COORD_BITS-1:0]     spec_x_out,
	output logic [COORD_BITS-1:0]     spec_y_out
);

	localparam int NW = 3 * COORD_BITS + 2;
	localparam int DW = 2 * COORD_BITS + 1;
	localparam int QB = COORD_BITS + 1;

	pfp_ctrl_t        ctrl_q;
	logic [NW-1:0]    rem_x_q, rem_y_q;
	logic [DW-1:0]    den_q;
	logic [QB-1:0]    quo_x_q, quo_y_q;
	logic [COORD_BITS-1:0] spec_x_q, spec_y_q;

	logic [NW:0]      dsh, diff_x, diff_y;
	logic             take_x, take_y;
	logic [QB-1:0]    bit_mask;

	// Trial subtraction of the shifted denominator for both coordinates.
	assign dsh      = {{(NW + 1 - DW){1'b0}}, den_in} << SHIFT;
	assign diff_x   = {1'b0, rem_x_in} - dsh;
	assign diff_y   = {1'b0, rem_y_in} - dsh;
	assign take_x   = !diff_x[NW];
	assign take_y   = !diff_y[NW];
	assign bit_mask = {{(QB - 1){1'b0}}, 1'b1} << SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	// Keep the reduced remainder and set this cell's quotient bit.
	always_ff @(posedge clk) begin
		rem_x_q  <= take_x ? diff_x[NW-1:0] : rem_x_in;
		rem_y_q  <= take_y ? diff_y[NW-1:0] : rem_y_in;
		quo_x_q  <= take_x ? (quo_x_in | bit_mask) : quo_x_in;
		quo_y_q  <= take_y ? (quo_y_in | bit_mask) : quo_y_in;
		den_q    <= den_in;
		spec_x_q <= spec_x_in;
		spec_y_q <= spec_y_in;
	end

	assign ctrl_out   = ctrl_q;
	assign rem_x_out  = rem_x_q;
	assign rem_y_out  = rem_y_q;
	assign den_out    = den_q;
	assign quo_x_out  = quo_x_q;
	assign quo_y_out  = quo_y_q;
	assign spec_x_out = spec_x_q;
	assign spec_y_out = spec_y_q;

endmodule

### design/perpendicular_foot_point.sv
// Channel   Signals                                    Handshake
// request   point_x/y, line_start_x/y, line_end_x/y    start high, busy low
// result    foot_x, foot_y                             done, one cycle, no stall
//
// A request is taken in every clock cycle; busy stays low.
// The result of a request passes five front stages, one divider cell per quotient
// bit (COORD_BITS+1 cells) and the output register.
// Reset clears the valid flags of every stage, so requests in flight are dropped.
// The receiver cannot stall: done is high for exactly one cycle per request.
module perpendicular_foot_point import pfp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_BITS-1:0]  point_x,
	input  logic [COORD_BITS-1:0]  point_y,
	input  logic [COORD_BITS-1:0]  line_start_x,
	input  logic [COORD_BITS-1:0]  line_start_y,
	input  logic [COORD_BITS-1:0]  line_end_x,
	input  logic [COORD_BITS-1:0]  line_end_y,
	output logic                   done,
	output logic [FOOT_BITS-1:0]   foot_x,
	output logic [FOOT_BITS-1:0]   foot_y
);

	localparam int NW = 3 * COORD_BITS + 2;
	localparam int DW = 2 * COORD_BITS + 1;
	localparam int QB = COORD_BITS + 1;

	pfp_ctrl_t             ctrl_c   [QB+1];
	logic [NW-1:0]         rem_x_c  [QB+1];
	logic [NW-1:0]         rem_y_c  [QB+1];
	logic [DW-1:0]         den_c    [QB+1];
	logic [QB-1:0]         quo_x_c  [QB+1];
	logic [QB-1:0]         quo_y_c  [QB+1];
	logic [COORD_BITS-1:0] spec_x_c [QB+1];
	logic [COORD_BITS-1:0] spec_y_c [QB+1];

	pfp_ctrl_t             last;
	logic signed [QB:0]    val_x, val_y;
	logic [FOOT_BITS-1:0]  res_x, res_y;
	logic                  done_q;
	logic [FOOT_BITS-1:0]  foot_x_q, foot_y_q;

	assign busy = 1'b0;

	// Numerators, denominator and special-case coordinates.
	pfp_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.line_start_x (line_start_x),
		.line_start_y (line_start_y),
		.line_end_x   (line_end_x),
		.line_end_y   (line_end_y),
		.ctrl         (ctrl_c[0]),
		.rem_x        (rem_x_c[0]),
		.rem_y        (rem_y_c[0]),
		.den          (den_c[0]),
		.spec_x       (spec_x_c[0]),
		.spec_y       (spec_y_c[0])
	);

	assign quo_x_c[0] = '0;
	assign quo_y_c[0] = '0;

	// Divider chain, most significant quotient bit first.
	for (genvar j = 0; j < QB; j++) begin : g_cell
		pfp_div_cell #(
			.COORD_BITS (COORD_BITS),
			.SHIFT      (QB - 1 - j)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl_in    (ctrl_c[j]),
			.rem_x_in   (rem_x_c[j]),
			.rem_y_in   (rem_y_c[j]),
			.den_in     (den_c[j]),
			.quo_x_in   (quo_x_c[j]),
			.quo_y_in   (quo_y_c[j]),
			.spec_x_in  (spec_x_c[j]),
			.spec_y_in  (spec_y_c[j]),
			.ctrl_out   (ctrl_c[j+1]),
			.rem_x_out  (rem_x_c[j+1]),
			.rem_y_out  (rem_y_c[j+1]),
			.den_out    (den_c[j+1]),
			.quo_x_out  (quo_x_c[j+1]),
			.quo_y_out  (quo_y_c[j+1]),
			.spec_x_out (spec_x_c[j+1]),
			.spec_y_out (spec_y_c[j+1])
		);
	end

	// Restore the sign, pick the special case and clamp to the result range.
	assign last  = ctrl_c[QB];
	assign val_x = last.neg_x ? -$signed({1'b0, quo_x_c[QB]}) : $signed({1'b0, quo_x_c[QB]});
	assign val_y = last.neg_y ? -$signed({1'b0, quo_y_c[QB]}) : $signed({1'b0, quo_y_c[QB]});

	always_comb begin
		if (last.vert || last.horiz) begin
			res_x = pfp_sat(32'(spec_x_c[QB]));
			res_y = pfp_sat(32'(spec_y_c[QB]));
		end else begin
			res_x = pfp_sat(32'(val_x));
			res_y = pfp_sat(32'(val_y));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		foot_x_q <= res_x;
		foot_y_q <= res_y;
	end

	assign done   = done_q;
	assign foot_x = foot_x_q;
	assign foot_y = foot_y_q;

endmodule

### design/pfp_checker.sv
module pfp_checker import pfp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [COORD_BITS-1:0]  point_x,
	input logic [COORD_BITS-1:0]  point_y,
	input logic [COORD_BITS-1:0]  line_start_x,
	input logic [COORD_BITS-1:0]  line_start_y,
	input logic [COORD_BITS-1:0]  line_end_x,
	input logic [COORD_BITS-1:0]  line_end_y,
	input logic                   done,
	input logic [FOOT_BITS-1:0]   foot_x,
	input logic [FOOT_BITS-1:0]   foot_y
);

	localparam int LAT = pfp_latency(COORD_BITS);

	// Every accepted request produces its result after the fixed latency.
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request without result");

	// No result appears without a request at the matching earlier edge.
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without request");

	// A vertical line (or identical end points) yields the line column and query row.
	a_vertical: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (line_start_x == line_end_x), LAT) |->
		foot_x == pfp_sat(32'($past(line_start_x, LAT))) &&
		foot_y == pfp_sat(32'($past(point_y, LAT))))
		else $error("wrong foot for a vertical line");

	// A horizontal line yields the query column and line row.
	a_horizontal: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (line_start_x != line_end_x) &&
		(line_start_y == line_end_y), LAT) |->
		foot_x == pfp_sat(32'($past(point_x, LAT))) &&
		foot_y == pfp_sat(32'($past(line_start_y, LAT))))
		else $error("wrong foot for a horizontal line");

endmodule

bind perpendicular_foot_point pfp_checker #(
	.COORD_BITS(COORD_BITS)
) u_pfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.point_x      (point_x),
	.point_y      (point_y),
	.line_start_x (line_start_x),
	.line_start_y (line_start_y),
	.line_end_x   (line_end_x),
	.line_end_y   (line_end_y),
	.done         (done),
	.foot_x       (foot_x),
	.foot_y       (foot_y)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import pfp_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int CMAX = (1 << CW) - 1;
	localparam int N_RANDOM = 850;
	localparam int DRAIN = 2 * pfp_latency(CW);
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX = 10;
	localparam int N_DIR = 14;

	typedef logic [CW-1:0] coord_t;
	typedef logic [FOOT_BITS-1:0] foot_coord_t;

	typedef struct {
		foot_coord_t fx;
		foot_coord_t fy;
	} foot_t;

	// One request row: query pixel, both line ends and an optional typed-in foot.
	typedef struct {
		coord_t px;
		coord_t py;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		bit preset;
		foot_coord_t fx;
		foot_coord_t fy;
	} req_row_t;

	typedef struct {
		bit valid;
		foot_t foot;
	} preset_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t point_x;
	coord_t point_y;
	coord_t line_start_x;
	coord_t line_start_y;
	coord_t line_end_x;
	coord_t line_end_y;
	logic done;
	foot_coord_t foot_x;
	foot_coord_t foot_y;

	foot_t foot_q[$];
	preset_t preset_q[$];
	int fail_count = 0;
	int cycle_count = 0;
	int n_accepted = 0;
	int n_vert = 0;
	int n_horiz = 0;
	int n_general = 0;
	int n_neg = 0;
	int burst_left = 0;

	// Directed requests. Vertical, horizontal and degenerate lines carry their
	// foot typed in; the sloped lines are left to the predictor.
	req_row_t dir_tab [N_DIR] = '{
		'{12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 15'd0,    15'd0},
		'{12'd0,    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 15'd4095, 15'd4095},
		'{12'd123,  12'd4000, 12'd2048, 12'd0,    12'd2048, 12'd4095, 1'b1, 15'd2048, 15'd4000},
		'{12'd4095, 12'd0,    12'd0,    12'd4095, 12'd0,    12'd0,    1'b1, 15'd0,    15'd0},
		'{12'd4095, 12'd17,   12'd0,    12'd4095, 12'd4095, 12'd4095, 1'b1, 15'd4095, 15'd4095},
		'{12'd0,    12'd4095, 12'd100,  12'd0,    12'd3000, 12'd0,    1'b1, 15'd0,    15'd0},
		'{12'd5,    12'd4090, 12'd1000, 12'd2000, 12'd1000, 12'd2000, 1'b1, 15'd1000, 15'd4090},
		'{12'd4095, 12'd0,    12'd0,    12'd0,    12'd4095, 12'd4095, 1'b0, 15'd0,    15'd0},
		'{12'd0,    12'd0,    12'd0,    12'd4095, 12'd4095, 12'd0,    1'b0, 15'd0,    15'd0},
		'{12'd0,    12'd4095, 12'd0,    12'd1,    12'd1,    12'd0,    1'b0, 15'd0,    15'd0},
		'{12'd0,    12'd4094, 12'd0,    12'd1,    12'd1,    12'd0,    1'b0, 15'd0,    15'd0},
		'{12'd4095, 12'd0,    12'd1,    12'd0,    12'd0,    12'd1,    1'b0, 15'd0,    15'd0},
		'{12'd4095, 12'd0,    12'd0,    12'd0,    12'd1,    12'd4095, 1'b0, 15'd0,    15'd0},
		'{12'd1234, 12'd2345, 12'd100,  12'd200,  12'd300,  12'd600,  1'b0, 15'd0,    15'd0}
	};

	perpendicular_foot_point i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.line_start_x (line_start_x),
		.line_start_y (line_start_y),
		.line_end_x   (line_end_x),
		.line_end_y   (line_end_y),
		.done         (done),
		.foot_x       (foot_x),
		.foot_y       (foot_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a coordinate into the 15-bit result range.
	function automatic foot_coord_t clamp_foot(input longint v);
		longint r;
		r = v;
		if (r > 16383) begin
			r = 16383;
		end
		if (r < -16384) begin
			r = -16384;
		end
		return r[FOOT_BITS-1:0];
	endfunction

	// Foot of the perpendicular from the query pixel onto the line through the ends.
	function automatic foot_t predict_foot(input coord_t px, input coord_t py,
			input coord_t sx, input coord_t sy, input coord_t ex, input coord_t ey);
		longint x0, y0, x1, y1, x2, y2;
		longint a, b, c, den, nx, ny;
		foot_t r;
		x0 = longint'(px);
		y0 = longint'(py);
		x1 = longint'(sx);
		y1 = longint'(sy);
		x2 = longint'(ex);
		y2 = longint'(ey);
		if (x1 == x2) begin
			nx = x1;
			ny = y0;
		end else if (y1 == y2) begin
			nx = x0;
			ny = y1;
		end else begin
			a = -(y2 - y1);
			b = x2 - x1;
			c = (y2 - y1) * x1 - (x2 - x1) * y1;
			den = a * a + b * b;
			nx = (b * b * x0 - a * b * y0 - a * c) / den;
			ny = (a * a * y0 - a * b * x0 - b * c) / den;
		end
		r.fx = clamp_foot(nx);
		r.fy = clamp_foot(ny);
		return r;
	endfunction

	// Coordinates lean toward the image borders now and then.
	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return coord_t'(CMAX);
		end
		return coord_t'($urandom_range(0, CMAX));
	endfunction

	// Random request: mostly general lines, with a share of the special shapes
	// and of short lines whose ends lie a few pixels apart.
	function automatic req_row_t rand_row();
		req_row_t r;
		int kind;
		r.px = rand_coord();
		r.py = rand_coord();
		r.sx = rand_coord();
		r.sy = rand_coord();
		r.ex = rand_coord();
		r.ey = rand_coord();
		r.preset = 1'b0;
		r.fx = '0;
		r.fy = '0;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			r.ex = r.sx;
		end else if (kind < 20) begin
			r.ey = r.sy;
		end else if (kind < 24) begin
			r.ex = r.sx;
			r.ey = r.sy;
		end else if (kind < 40) begin
			r.ex = r.sx ^ coord_t'($urandom_range(1, 7));
			r.ey = r.sy ^ coord_t'($urandom_range(1, 7));
		end
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOW_MAX) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Drive one request after a random gap and hold it until it is taken.
	task automatic send_request(input req_row_t r);
		int gap;
		preset_t p;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 49) == 0) begin
			burst_left = $urandom_range(20, 60);
			gap = 0;
		end else if ($urandom_range(0, 9) < 6) begin
			gap = 0;
		end else if ($urandom_range(0, 9) < 8) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.valid = r.preset;
		p.foot.fx = r.fx;
		p.foot.fy = r.fy;
		preset_q.push_back(p);
		start <= 1'b1;
		point_x <= r.px;
		point_y <= r.py;
		line_start_x <= r.sx;
		line_start_y <= r.sy;
		line_end_x <= r.ex;
		line_end_y <= r.ey;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Check each result against the oldest expectation, then record the
	// expectation of a request taken at this edge.
	always @(posedge clk) begin : result_check
		foot_t want;
		preset_t p;
		foot_t pred;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (foot_q.size() == 0) begin
					note_failure($sformatf("result (%0d,%0d) with no request pending",
						$signed(foot_x), $signed(foot_y)));
				end else begin
					want = foot_q.pop_front();
					if (foot_x !== want.fx) begin
						note_failure($sformatf("foot_x expected %0d got %0d",
							$signed(want.fx), $signed(foot_x)));
					end
					if (foot_y !== want.fy) begin
						note_failure($sformatf("foot_y expected %0d got %0d",
							$signed(want.fy), $signed(foot_y)));
					end
				end
			end
			if (start && !busy) begin
				p = preset_q.pop_front();
				pred = predict_foot(point_x, point_y, line_start_x, line_start_y,
					line_end_x, line_end_y);
				foot_q.push_back(p.valid ? p.foot : pred);
				n_accepted++;
				if (line_start_x == line_end_x) begin
					n_vert++;
				end else if (line_start_y == line_end_y) begin
					n_horiz++;
				end else begin
					n_general++;
				end
				if (pred.fx[FOOT_BITS-1] || pred.fy[FOOT_BITS-1]) begin
					n_neg++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, foot_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Reset, directed table, random requests, drain and verdict.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		line_start_x = '0;
		line_start_y = '0;
		line_end_x = '0;
		line_end_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++) begin
			send_request(dir_tab[i]);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_request(rand_row());
		end
		start <= 1'b0;
		while (foot_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Requests taken: %0d (vertical or degenerate %0d, horizontal %0d, sloped %0d).",
			n_accepted, n_vert, n_horiz, n_general);
		$display("Feet with a negative coordinate: %0d; mismatches: %0d.", n_neg, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
